// ===== design/lrd_pkg.sv =====
// Shared types and codes for the log record deframer.
package lrd_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_CODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODIFY_CODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELETE_CODE = 2'd2;

	// Byte roles.
	localparam logic [2:0] ROLE_CMD     = 3'd0;
	localparam logic [2:0] ROLE_KEY_LEN = 3'd1;
	localparam logic [2:0] ROLE_VAL_LEN = 3'd2;
	localparam logic [2:0] ROLE_KEY     = 3'd3;
	localparam logic [2:0] ROLE_VAL     = 3'd4;
	localparam logic [2:0] ROLE_IGNORED = 3'd5;

	// Command classes.
	localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
	localparam logic [1:0] CLASS_SET     = 2'd1;
	localparam logic [1:0] CLASS_MODIFY  = 2'd2;
	localparam logic [1:0] CLASS_DELETE  = 2'd3;

	// Result status.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

	// Varint fields.
	localparam logic [6:0] PAYLOAD_MASK = 7'h7F;
	localparam int         CONT_POS     = 7;
	localparam logic [5:0] SHIFT_MAX    = 6'd63;
	localparam logic [6:0] GROUP_BITS   = 7'd7;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_KLEN = 6'b000010,
		PH_VLEN = 6'b000100,
		PH_KEY  = 6'b001000,
		PH_VAL  = 6'b010000,
		PH_SKIP = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  byte_role;
		logic [7:0]  data_byte;
		logic [1:0]  command_class;
		logic [31:0] key_length;
		logic [31:0] value_length;
		logic        record_done;
		logic [1:0]  status;
	} out_item_t;

	// What the parser hands on for one byte, before classification.
	typedef struct packed {
		logic [2:0]  byte_role;
		logic [7:0]  data_byte;
		logic [7:0]  command_byte;
		logic [31:0] key_length;
		logic [31:0] value_length;
		logic        record_done;
		logic [1:0]  status;
	} step_t;

endpackage

// ===== design/lrd_cfg.sv =====
// Command code registers and command byte classification.
module lrd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [lrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic [7:0]                     command_byte,
	output logic [1:0]                     command_class
);

	logic [7:0] set_code_q;
	logic [7:0] modify_code_q;
	logic [7:0] delete_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_code_q    <= 8'd1;
			modify_code_q <= 8'd2;
			delete_code_q <= 8'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lrd_pkg::CFG_SET_CODE:    set_code_q    <= cfg_data;
				lrd_pkg::CFG_MODIFY_CODE: modify_code_q <= cfg_data;
				lrd_pkg::CFG_DELETE_CODE: delete_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Set wins over modify, modify over delete when codes collide.
	always_comb begin
		priority if (command_byte == set_code_q) begin
			command_class = lrd_pkg::CLASS_SET;
		end else if (command_byte == modify_code_q) begin
			command_class = lrd_pkg::CLASS_MODIFY;
		end else if (command_byte == delete_code_q) begin
			command_class = lrd_pkg::CLASS_DELETE;
		end else begin
			command_class = lrd_pkg::CLASS_UNKNOWN;
		end
	end

endmodule

// ===== design/lrd_parser.sv =====
// Record framing state machine: varint length decode and byte counting.
module lrd_parser #(
	parameter int LEN_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  lrd_pkg::in_item_t item,
	output lrd_pkg::step_t    step
);

	// Widest shifted payload: seven bits at a shift of up to 63.
	localparam int SW = 64 + 7;

	lrd_pkg::phase_t     phase_q, phase_n;
	logic [7:0]          cmd_q, cmd_n;
	logic [LEN_BITS-1:0] klen_q, klen_n;
	logic [LEN_BITS-1:0] vlen_q, vlen_n;
	logic [LEN_BITS-1:0] left_q, left_n;
	logic [5:0]          gs_q, gs_n;
	logic                err_q, err_n;

	logic [SW-1:0]       wide;
	logic                ovf;
	logic [LEN_BITS-1:0] addv;
	logic [6:0]          gs_sum;
	logic [5:0]          gs_inc;
	logic [LEN_BITS-1:0] vlen_new;
	logic                cont;
	logic                left_last;
	logic [2:0]          role;
	logic                done;
	logic [1:0]          status;

	assign cont      = item.in_byte[lrd_pkg::CONT_POS];
	assign wide      = SW'(item.in_byte[6:0] & lrd_pkg::PAYLOAD_MASK) << gs_q;
	assign ovf       = |wide[SW-1:LEN_BITS];
	assign addv      = wide[LEN_BITS-1:0];
	assign gs_sum    = {1'b0, gs_q} + lrd_pkg::GROUP_BITS;
	assign gs_inc    = gs_sum[6] ? lrd_pkg::SHIFT_MAX : gs_sum[5:0];
	assign vlen_new  = vlen_q | addv;
	assign left_last = (left_q[LEN_BITS-1:1] == '0);

	always_comb begin
		phase_n = phase_q;
		cmd_n   = cmd_q;
		klen_n  = klen_q;
		vlen_n  = vlen_q;
		left_n  = left_q;
		gs_n    = gs_q;
		err_n   = err_q;
		role    = lrd_pkg::ROLE_IGNORED;
		done    = 1'b0;
		status  = lrd_pkg::STATUS_OK;

		unique case (phase_q)
			lrd_pkg::PH_IDLE: begin
				role    = lrd_pkg::ROLE_CMD;
				cmd_n   = item.in_byte;
				klen_n  = '0;
				vlen_n  = '0;
				gs_n    = '0;
				phase_n = lrd_pkg::PH_KLEN;
			end
			lrd_pkg::PH_KLEN: begin
				role = lrd_pkg::ROLE_KEY_LEN;
				if (ovf) begin
					err_n   = 1'b1;
					phase_n = lrd_pkg::PH_SKIP;
				end else begin
					klen_n = klen_q | addv;
					gs_n   = gs_inc;
					if (!cont) begin
						gs_n    = '0;
						phase_n = lrd_pkg::PH_VLEN;
					end
				end
			end
			lrd_pkg::PH_VLEN: begin
				role = lrd_pkg::ROLE_VAL_LEN;
				if (ovf) begin
					err_n   = 1'b1;
					phase_n = lrd_pkg::PH_SKIP;
				end else begin
					vlen_n = vlen_new;
					gs_n   = gs_inc;
					if (!cont) begin
						gs_n = '0;
						if (klen_q != '0) begin
							left_n  = klen_q;
							phase_n = lrd_pkg::PH_KEY;
						end else if (vlen_new != '0) begin
							left_n  = vlen_new;
							phase_n = lrd_pkg::PH_VAL;
						end else begin
							done    = 1'b1;
							phase_n = lrd_pkg::PH_IDLE;
						end
					end
				end
			end
			lrd_pkg::PH_KEY: begin
				role = lrd_pkg::ROLE_KEY;
				if (left_last) begin
					if (vlen_q != '0) begin
						left_n  = vlen_q;
						phase_n = lrd_pkg::PH_VAL;
					end else begin
						left_n  = '0;
						done    = 1'b1;
						phase_n = lrd_pkg::PH_IDLE;
					end
				end else begin
					left_n = left_q - LEN_BITS'(1);
				end
			end
			lrd_pkg::PH_VAL: begin
				role = lrd_pkg::ROLE_VAL;
				if (left_last) begin
					left_n  = '0;
					done    = 1'b1;
					phase_n = lrd_pkg::PH_IDLE;
				end else begin
					left_n = left_q - LEN_BITS'(1);
				end
			end
			lrd_pkg::PH_SKIP: begin
				role = lrd_pkg::ROLE_IGNORED;
			end
			default: begin
				role = lrd_pkg::ROLE_IGNORED;
			end
		endcase

		// An overflow poisons the rest of the stream; the overflowing length
		// byte itself keeps its length role.
		if (err_n) begin
			status = lrd_pkg::STATUS_OVERFLOW;
			done   = 1'b0;
			if (role != lrd_pkg::ROLE_KEY_LEN && role != lrd_pkg::ROLE_VAL_LEN) begin
				role = lrd_pkg::ROLE_IGNORED;
			end
		end else if (item.stream_end && !done) begin
			status = lrd_pkg::STATUS_TRUNCATED;
		end

		if (item.stream_end) begin
			phase_n = lrd_pkg::PH_IDLE;
			gs_n    = '0;
			left_n  = '0;
			err_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lrd_pkg::PH_IDLE;
			cmd_q   <= '0;
			klen_q  <= '0;
			vlen_q  <= '0;
			left_q  <= '0;
			gs_q    <= '0;
			err_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			cmd_q   <= cmd_n;
			klen_q  <= klen_n;
			vlen_q  <= vlen_n;
			left_q  <= left_n;
			gs_q    <= gs_n;
			err_q   <= err_n;
		end
	end

	always_comb begin
		step.byte_role    = role;
		step.data_byte    = item.in_byte;
		step.command_byte = cmd_n;
		step.key_length   = 32'(klen_n);
		step.value_length = 32'(vlen_n);
		step.record_done  = done;
		step.status       = status;
	end

	a_skip_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lrd_pkg::PH_SKIP) |-> err_q)
		else $error("skip phase without a recorded overflow");

	a_idle_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lrd_pkg::PH_IDLE) |-> !err_q)
		else $error("error flag held while idle");

endmodule

// ===== design/log_record_deframer.sv =====
// Top level of the log record deframer: input register, parser, result register.
//
//  channel   handshake              payload
//  -------   ---------------------  --------------------------------------
//  item      item_valid/item_ready  item   (in_byte, stream_end)
//  result    result_valid/ready     result (role, byte, class, lengths, ...)
//  cfg       cfg_valid/cfg_ready    cfg_index, cfg_data (command codes)
//
// One beat per clock in steady state while result_ready is high. An accepted byte
// waits in the input register, then is parsed into the result register.
// The parser state updates in the same cycle the byte moves into the result register.
// When result_ready is low, one byte waits in the input register and one in
// the result register; item_ready then drops. Reset clears all control state
// and loads the command codes 1, 2 and 3. cfg_ready is always high.
module log_record_deframer #(
	parameter int LEN_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  lrd_pkg::in_item_t             item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output lrd_pkg::out_item_t            result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lrd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);

	lrd_pkg::in_item_t  item_s1;
	logic               valid_s1;
	lrd_pkg::out_item_t result_s2;
	logic               valid_s2;

	lrd_pkg::step_t     step;
	logic [1:0]         command_class;
	logic               advance;
	logic               fire;

	assign advance    = !valid_s2 || result_ready;
	assign fire       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	lrd_parser #(
		.LEN_BITS(LEN_BITS)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.step  (step)
	);

	lrd_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command_byte (step.command_byte),
		.command_class(command_class)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2.byte_role     <= step.byte_role;
			result_s2.data_byte     <= step.data_byte;
			result_s2.command_class <= command_class;
			result_s2.key_length    <= step.key_length;
			result_s2.value_length  <= step.value_length;
			result_s2.record_done   <= step.record_done;
			result_s2.status        <= step.status;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s2 || result_ready) |-> item_ready)
		else $error("input stalled while the result register can drain");

	a_done_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.record_done) |-> (result_s2.status == lrd_pkg::STATUS_OK))
		else $error("record done reported with a bad status");

	a_ignored_is_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.byte_role == lrd_pkg::ROLE_IGNORED)
			|-> (result_s2.status == lrd_pkg::STATUS_OVERFLOW))
		else $error("ignored byte without an overflow status");

	a_cmd_zero_lengths: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.byte_role == lrd_pkg::ROLE_CMD)
			|-> (result_s2.key_length == '0 && result_s2.value_length == '0))
		else $error("command beat carries nonzero lengths");

endmodule
